// ===== rtl/s5rp_pkg.sv =====
// s5rp_pkg: shared types and constants for the SOCKS5 reply parser.
// No dependencies; imported by the unit, input stage, parser and checker.
package s5rp_pkg;

    localparam logic [7:0] SOCKS_VERSION  = 8'h05;
    localparam logic [7:0] METHOD_NONE    = 8'h00;
    localparam logic [7:0] METHOD_REFUSED = 8'hff;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_NAME      = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;
    localparam logic [8:0] IPV4_TAIL      = 9'd6;
    localparam logic [8:0] IPV6_TAIL      = 9'd18;
    localparam logic [8:0] PORT_BYTES     = 9'd2;

    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_AUTH_OK     = 4'd1;
    localparam logic [3:0] ST_CONNECTED   = 4'd2;
    localparam logic [3:0] ST_BAD_AUTH    = 4'd3;
    localparam logic [3:0] ST_REFUSED     = 4'd4;
    localparam logic [3:0] ST_BAD_VERSION = 4'd5;
    localparam logic [3:0] ST_SERVER_ERR  = 4'd6;
    localparam logic [3:0] ST_BAD_ATYP    = 4'd7;
    localparam logic [3:0] ST_EOF         = 4'd8;
    localparam logic [3:0] ST_FINISHED    = 4'd9;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_stream;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] server_code;
        logic       finished;
    } t_result;

endpackage

// ===== rtl/s5rp_if.sv =====
// s5rp_if: valid/ready channel interfaces for input bytes and results.
// Depends on nothing; used by the top level and the input stage.
interface s5rp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_stream;
    logic       restart;

    modport source(output valid, output rx_byte, output end_of_stream, output restart,
                   input ready);
    modport sink(input valid, input rx_byte, input end_of_stream, input restart,
                 output ready);
endinterface

interface s5rp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] server_code;
    logic       finished;

    modport source(output valid, output status, output server_code, output finished,
                   input ready);
    modport sink(input valid, input status, input server_code, input finished,
                 output ready);
endinterface

// ===== rtl/socks5_reply_parser_unit.sv =====
// SOCKS5 reply parser: one received byte per word, one status word per byte.
// Path: input register, then result register.
// Throughput: one word per cycle unless o_out stalls; the parser state updates
// as a word moves from the input register to the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to awaiting the method reply. Depends on s5rp_pkg, s5rp_if.
module socks5_reply_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s5rp_in_if.sink    i_in,
    s5rp_out_if.source o_out
);
    import s5rp_pkg::*;

    logic     in_valid;
    t_in_word in_word;
    logic     advance;
    t_result  result;

    logic     r_out_valid;
    t_result  r_out;

    assign advance = in_valid && (!r_out_valid || o_out.ready);

    s5rp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_word    (in_word)
    );

    s5rp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.server_code = r_out.server_code;
    assign o_out.finished    = r_out.finished;
endmodule

// ===== rtl/s5rp_in_stage.sv =====
// s5rp_in_stage: input register; captures one word per cycle unless stalled.
// Depends on s5rp_pkg and s5rp_if.
module s5rp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    s5rp_in_if.sink           i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output s5rp_pkg::t_in_word o_word
);
    import s5rp_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // refill whenever empty or the held word moves on this cycle
    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.rx_byte       <= i_in.rx_byte;
            r_word.end_of_stream <= i_in.end_of_stream;
            r_word.restart       <= i_in.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

// ===== rtl/s5rp_parser.sv =====
// s5rp_parser: negotiation state and per-byte decode of method and connect replies.
// Depends on s5rp_pkg.
module s5rp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  s5rp_pkg::t_in_word i_word,
    output s5rp_pkg::t_result  o_result
);
    import s5rp_pkg::*;

    localparam logic [1:0] PH_METHOD  = 2'd0;
    localparam logic [1:0] PH_CONNECT = 2'd1;
    localparam logic [1:0] PH_ENDED   = 2'd2;

    localparam logic [2:0] IDX_VER   = 3'd0;
    localparam logic [2:0] IDX_REP   = 3'd1;
    localparam logic [2:0] IDX_RSV   = 3'd2;
    localparam logic [2:0] IDX_ATYP  = 3'd3;
    localparam logic [2:0] IDX_TAIL  = 3'd4;

    logic [1:0] r_phase,     n_phase;
    logic [2:0] r_idx,       n_idx;
    logic [8:0] r_remain,    n_remain;
    logic       r_await_len, n_await_len;
    logic [7:0] r_first,     n_first;
    logic [3:0] r_held_st,   n_held_st;
    logic [7:0] r_held_code, n_held_code;

    t_result    res;
    logic [8:0] remain_dec;

    assign remain_dec = (r_remain != 9'd0) ? r_remain - 9'd1 : r_remain;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_remain    = r_remain;
        n_await_len = r_await_len;
        n_first     = r_first;
        n_held_st   = r_held_st;
        n_held_code = r_held_code;
        res         = '{status: ST_BUSY, server_code: 8'd0, finished: 1'b0};

        if (i_word.restart) begin
            n_phase     = PH_METHOD;
            n_idx       = IDX_VER;
            n_remain    = 9'd0;
            n_await_len = 1'b0;
            n_first     = 8'd0;
            n_held_st   = ST_BUSY;
            n_held_code = 8'd0;
        end else if (r_phase == PH_ENDED) begin
            res = '{status: r_held_st, server_code: r_held_code, finished: 1'b1};
        end else if (i_word.end_of_stream) begin
            res = '{status: ST_EOF, server_code: 8'd0, finished: 1'b1};
        end else if (r_phase == PH_METHOD) begin
            if (r_idx == IDX_VER) begin
                n_first = i_word.rx_byte;
                n_idx   = IDX_REP;
            end else if (r_first != SOCKS_VERSION ||
                         (i_word.rx_byte != METHOD_NONE &&
                          i_word.rx_byte != METHOD_REFUSED)) begin
                res = '{status: ST_BAD_AUTH, server_code: 8'd0, finished: 1'b1};
            end else if (i_word.rx_byte == METHOD_REFUSED) begin
                res = '{status: ST_REFUSED, server_code: 8'd0, finished: 1'b1};
            end else begin
                n_phase = PH_CONNECT;
                n_idx   = IDX_VER;
                res.status = ST_AUTH_OK;
            end
        end else begin
            unique case (r_idx)
                IDX_VER: begin
                    if (i_word.rx_byte != SOCKS_VERSION) begin
                        res = '{status: ST_BAD_VERSION, server_code: 8'd0, finished: 1'b1};
                    end else begin
                        n_idx = IDX_REP;
                    end
                end
                IDX_REP: begin
                    if (i_word.rx_byte != 8'd0) begin
                        res = '{status: ST_SERVER_ERR, server_code: i_word.rx_byte,
                                finished: 1'b1};
                    end else begin
                        n_idx      = IDX_RSV;
                        res.status = ST_CONNECTED;
                    end
                end
                IDX_RSV: begin
                    n_idx      = IDX_ATYP;
                    res.status = ST_CONNECTED;
                end
                IDX_ATYP: begin
                    res.status = ST_CONNECTED;
                    n_idx      = IDX_TAIL;
                    if (i_word.rx_byte == ATYP_IPV4) begin
                        n_remain = IPV4_TAIL;
                    end else if (i_word.rx_byte == ATYP_IPV6) begin
                        n_remain = IPV6_TAIL;
                    end else if (i_word.rx_byte == ATYP_NAME) begin
                        n_await_len = 1'b1;
                    end else begin
                        n_idx = r_idx;
                        res   = '{status: ST_BAD_ATYP, server_code: 8'd0, finished: 1'b1};
                    end
                end
                default: begin
                    // tail: name length byte, then address and port count-down
                    if (r_await_len) begin
                        n_await_len = 1'b0;
                        n_remain    = {1'b0, i_word.rx_byte} + PORT_BYTES;
                        res.status  = ST_CONNECTED;
                    end else begin
                        n_remain = remain_dec;
                        if (remain_dec == 9'd0) begin
                            res = '{status: ST_FINISHED, server_code: 8'd0, finished: 1'b1};
                        end else begin
                            res.status = ST_CONNECTED;
                        end
                    end
                end
            endcase
        end

        // any terminal result latches the ended state
        if (!i_word.restart && r_phase != PH_ENDED && res.finished) begin
            n_phase     = PH_ENDED;
            n_held_st   = res.status;
            n_held_code = res.server_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_METHOD;
            r_idx       <= IDX_VER;
            r_remain    <= 9'd0;
            r_await_len <= 1'b0;
            r_first     <= 8'd0;
            r_held_st   <= ST_BUSY;
            r_held_code <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_remain    <= n_remain;
            r_await_len <= n_await_len;
            r_first     <= n_first;
            r_held_st   <= n_held_st;
            r_held_code <= n_held_code;
        end
    end

    assign o_result = res;
endmodule

// ===== rtl/s5rp_checker.sv =====
// s5rp_checker: port-level assertions for socks5_reply_parser_unit, plus bind.
// Depends on s5rp_pkg and the top level's interface ports.
module s5rp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_status,
    input logic [7:0] i_server_code,
    input logic       i_finished
);
    import s5rp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_server_code) && $stable(i_finished))
        else $error("result word changed while stalled");

    // a rising result valid follows an input accept through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching input word");

    a_final_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_finished == (i_status >= ST_BAD_AUTH)) &&
            (i_server_code == 8'd0 || i_status == ST_SERVER_ERR))
        else $error("inconsistent status, finished or server code");
endmodule

bind socks5_reply_parser_unit s5rp_checker u_s5rp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_server_code (o_out.server_code),
    .i_finished    (o_out.finished)
);
